/* design/itdrw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdrw_pkg
// Shared widths, codes and control types of the digit register writer.
// ----------------------------------------------------------------------------
package itdrw_pkg;

   localparam int NUMBER_W           = 27;
   localparam int ADDR_W             = 4;
   localparam int DATA_W             = 8;
   localparam int NUM_DIGITS_W       = 4;
   localparam int DP_MASK_W          = 8;
   localparam int DP_IDX_W           = 3;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 8;

   localparam int DEF_MAX_DIGITS     = 8;
   localparam int DEF_DIGIT_REG_BASE = 1;

   localparam logic [NUM_DIGITS_W-1:0] NUM_DIGITS_RESET = 4'd8;
   localparam logic [DP_MASK_W-1:0]    DP_MASK_RESET    = 8'h00;

   localparam logic [DATA_W-1:0] BLANK_CODE = 8'h0F;
   localparam logic [DATA_W-1:0] POINT_CODE = 8'h80;

   // x / 10 == (x * RECIP_DIV10) >> RECIP_SHIFT for any 32-bit x
   localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = NUMBER_W + 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_NUM_DIGITS = 2'd0,
      REG_DP_MASK    = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic load;
      logic step;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic k_last;
   } ctrl_sts_type;

endpackage

/* design/itdrw_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdrw channels
// Valid/ready channels for the number input and the register write output.
// ----------------------------------------------------------------------------
interface itdrw_req_if;
   import itdrw_pkg::*;

   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface itdrw_rsp_if;
   import itdrw_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] reg_addr;
   logic [DATA_W-1:0] reg_data;
   logic              overflow;
   logic              last;

   modport source (output valid, output reg_addr, output reg_data, output overflow,
                   output last, input ready);
   modport sink   (input valid, input reg_addr, input reg_data, input overflow,
                   input last, output ready);
endinterface

/* design/itdrw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdrw_ctrl
// Sequencer: accept a number, run one digit step per cycle, then emit writes.
// ----------------------------------------------------------------------------
module itdrw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output itdrw_pkg::ctrl_cmd_type cmd,
   input  itdrw_pkg::ctrl_sts_type sts
);
   import itdrw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.step = 1'b1;
            if (sts.k_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.advance = 1'b1;
               if (sts.k_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("input taken while writes pending");

   a_load_to_calc: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (cmd.step && !in_ready))
      else $error("accepted item did not start digit steps");

   a_final_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.advance && sts.k_last) |=> (in_ready && !out_valid))
      else $error("no return to idle after final write");
`endif

endmodule

/* design/itdrw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdrw_datapath
// Config registers, divide-by-ten step, digit code store and write fields.
// ----------------------------------------------------------------------------
module itdrw_datapath #(
   parameter int MAX_DIGITS     = itdrw_pkg::DEF_MAX_DIGITS,
   parameter int DIGIT_REG_BASE = itdrw_pkg::DEF_DIGIT_REG_BASE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [itdrw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [itdrw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [itdrw_pkg::NUMBER_W-1:0]      number,
   input  itdrw_pkg::ctrl_cmd_type             cmd,
   output itdrw_pkg::ctrl_sts_type             sts,
   output logic [itdrw_pkg::ADDR_W-1:0]        reg_addr,
   output logic [itdrw_pkg::DATA_W-1:0]        reg_data,
   output logic                                overflow,
   output logic                                last
);
   import itdrw_pkg::*;

   localparam int K_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [NUM_DIGITS_W-1:0] num_digits_ff, num_digits_in;
   logic [DP_MASK_W-1:0]    dp_mask_ff, dp_mask_in;
   logic [NUMBER_W-1:0]     rest_ff, rest_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [DATA_W-1:0]       codes_ff [MAX_DIGITS];

   logic [NUM_DIGITS_W-1:0] n_eff;
   logic [NUM_DIGITS_W-1:0] idx;
   logic [PROD_W-1:0]       prod;
   logic [NUMBER_W-1:0]     quot;
   logic [NUMBER_W-1:0]     diff;
   logic [DATA_W-1:0]       code;

   always_comb begin
      num_digits_in = num_digits_ff;
      dp_mask_in    = dp_mask_ff;
      if (csr_we) begin
         if (csr_index == REG_NUM_DIGITS) begin
            num_digits_in = csr_wdata[NUM_DIGITS_W-1:0];
         end else if (csr_index == REG_DP_MASK) begin
            dp_mask_in = csr_wdata[DP_MASK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_digits_ff <= NUM_DIGITS_RESET;
         dp_mask_ff    <= DP_MASK_RESET;
      end else begin
         num_digits_ff <= num_digits_in;
         dp_mask_ff    <= dp_mask_in;
      end
   end

   always_comb begin
      if (num_digits_ff == '0) begin
         n_eff = NUM_DIGITS_W'(1);
      end else if (num_digits_ff > NUM_DIGITS_W'(MAX_DIGITS)) begin
         n_eff = NUM_DIGITS_W'(MAX_DIGITS);
      end else begin
         n_eff = num_digits_ff;
      end
   end

   assign idx        = n_eff - NUM_DIGITS_W'(1) - NUM_DIGITS_W'(k_ff);
   assign sts.k_last = (NUM_DIGITS_W'(k_ff) == (n_eff - NUM_DIGITS_W'(1)));

   assign prod = PROD_W'(rest_ff) * PROD_W'(RECIP_DIV10);
   assign quot = NUMBER_W'(prod >> RECIP_SHIFT);
   assign diff = rest_ff - ((quot << 3) + (quot << 1));

   always_comb begin
      if (rest_ff != '0) begin
         code = {4'h0, diff[3:0]};
         if (dp_mask_ff[idx[DP_IDX_W-1:0]]) begin
            code = code + POINT_CODE;
         end
      end else begin
         code = BLANK_CODE;
      end
   end

   always_comb begin
      rest_in = rest_ff;
      k_in    = k_ff;
      if (cmd.load) begin
         rest_in = number;
         k_in    = '0;
      end else if (cmd.step || cmd.advance) begin
         k_in = sts.k_last ? '0 : k_ff + K_W'(1);
         if (cmd.step) begin
            rest_in = quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      if (cmd.step) begin
         codes_ff[k_ff] <= code;
      end
   end

   assign reg_addr = ADDR_W'(DIGIT_REG_BASE) + ADDR_W'(idx);
   assign reg_data = codes_ff[k_ff];
   assign overflow = (rest_ff != '0);
   assign last     = sts.k_last;

`ifndef ASSERT_OFF
   a_rest_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> $stable(rest_ff))
      else $error("remainder changed during writes");
`endif

endmodule

/* design/int_to_digit_register_writes_unit.sv */
`timescale 1ns / 1ps
// Sequence: accept the number, run n digit steps (one divide-by-ten step each,
// n = digits in use, 1..MAX_DIGITS), then offer the first write.
// A new number is taken only after the previous one's final write, a limit
// set by the single shared divide-by-ten unit and MAX_DIGITS-entry code store.
// Reset (synchronous, active high): idle, num_digits = 8, dp_mask = 0.
// ----------------------------------------------------------------------------
// int_to_digit_register_writes_unit
// Turns a number into one display digit register write per digit in use.
// ----------------------------------------------------------------------------
module int_to_digit_register_writes_unit #(
   parameter int MAX_DIGITS     = itdrw_pkg::DEF_MAX_DIGITS,
   parameter int DIGIT_REG_BASE = itdrw_pkg::DEF_DIGIT_REG_BASE
) (
   input  logic                              clock,
   input  logic                              reset,
   itdrw_req_if.sink                         req_ch,
   itdrw_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [itdrw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [itdrw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import itdrw_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   itdrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itdrw_datapath #(
      .MAX_DIGITS     (MAX_DIGITS),
      .DIGIT_REG_BASE (DIGIT_REG_BASE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .number    (req_ch.number),
      .cmd       (cmd),
      .sts       (sts),
      .reg_addr  (rsp_ch.reg_addr),
      .reg_data  (rsp_ch.reg_data),
      .overflow  (rsp_ch.overflow),
      .last      (rsp_ch.last)
   );

endmodule

/* dv/int_to_digit_register_writes_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_digit_register_writes_unit_tb
// Feeds numbers through the digit register writer under several digit counts
// and decimal point masks. Each accepted number is expanded locally into the
// register writes it should cause, and every write taken from the block is
// checked field by field against the oldest of those. Both channels idle at
// random; one phase stalls the writes for a long stretch.
// ----------------------------------------------------------------------------
module int_to_digit_register_writes_unit_tb;
   import itdrw_pkg::*;

   localparam int MAX_DIGITS     = DEF_MAX_DIGITS;
   localparam int DIGIT_REG_BASE = DEF_DIGIT_REG_BASE;
   localparam int DRAIN_CYCLES   = 2 * MAX_DIGITS + 10;
   localparam int LONG_HOLD      = 300;
   localparam int STALL_LIMIT    = 4000;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 41;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] reg_addr;
      logic [DATA_W-1:0] reg_data;
      logic              overflow;
      logic              last;
   } digit_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   itdrw_req_if req_if ();
   itdrw_rsp_if rsp_if ();

   int_to_digit_register_writes_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   logic [NUMBER_W-1:0]   pending_numbers [$];
   digit_write_type       digit_writes_due [$];
   logic [NUM_DIGITS_W-1:0] cfg_num_digits;
   logic [DP_MASK_W-1:0]  cfg_dp_mask;
   int unsigned numbers_queued = 0;
   int unsigned numbers_taken  = 0;
   int unsigned err_count      = 0;
   int unsigned stall_cycles   = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic no_idle  = 1'b0;
   logic req_offering = 1'b0;
   int unsigned req_gap  = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_hold_left  = 0;
   int unsigned rsp_hold_token = 0;
   int unsigned rsp_hold_seen  = 0;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   // Expand one number into its digit register writes, rightmost digit first.
   task automatic predict_digit_writes(input logic [NUMBER_W-1:0] number);
      int unsigned rest;
      int unsigned n;
      int unsigned idx;
      logic [DATA_W-1:0] codes [MAX_DIGITS];
      logic ovf;
      digit_write_type w;
      rest = number;
      n = cfg_num_digits;
      if (n < 1) n = 1;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      for (int k = 0; k < n; k++) begin
         idx = n - 1 - k;
         if (rest != 0) begin
            codes[k] = DATA_W'(rest % 10);
            rest = rest / 10;
            if (cfg_dp_mask[idx % 8]) codes[k] = codes[k] + POINT_CODE;
         end else begin
            codes[k] = BLANK_CODE;
         end
      end
      ovf = (rest != 0);
      for (int k = 0; k < n; k++) begin
         idx = n - 1 - k;
         w.reg_addr = ADDR_W'(DIGIT_REG_BASE + idx);
         w.reg_data = codes[k];
         w.overflow = ovf;
         w.last     = (idx == 0);
         digit_writes_due.push_back(w);
      end
   endtask

   // Monitor, config shadow and watchdog
   always @(posedge clock) begin
      digit_write_type w;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (reset) begin
         cfg_num_digits = NUM_DIGITS_RESET;
         cfg_dp_mask    = DP_MASK_RESET;
         stall_cycles   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_NUM_DIGITS: cfg_num_digits = csr_wdata[NUM_DIGITS_W-1:0];
               REG_DP_MASK:    cfg_dp_mask    = csr_wdata[DP_MASK_W-1:0];
               default: ;
            endcase
         end
         req_fire = req_if.valid && req_if.ready;
         rsp_fire = rsp_if.valid && rsp_if.ready;
         if (req_fire) begin
            predict_digit_writes(req_if.number);
            numbers_taken++;
         end
         if (rsp_fire) begin
            if (digit_writes_due.size() == 0) begin
               report_error($sformatf("unexpected write addr %0h data %0h",
                                      rsp_if.reg_addr, rsp_if.reg_data));
            end else begin
               w = digit_writes_due.pop_front();
               if (rsp_if.reg_addr !== w.reg_addr)
                  report_error($sformatf("reg_addr got %0h exp %0h",
                                         rsp_if.reg_addr, w.reg_addr));
               if (rsp_if.reg_data !== w.reg_data)
                  report_error($sformatf("reg_data got %0h exp %0h (addr %0h)",
                                         rsp_if.reg_data, w.reg_data, w.reg_addr));
               if (rsp_if.overflow !== w.overflow)
                  report_error($sformatf("overflow got %0b exp %0b (addr %0h)",
                                         rsp_if.overflow, w.overflow, w.reg_addr));
               if (rsp_if.last !== w.last)
                  report_error($sformatf("last got %0b exp %0b (addr %0h)",
                                         rsp_if.last, w.last, w.reg_addr));
            end
         end
         if (req_fire || rsp_fire || csr_we) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("int_to_digit_register_writes_unit_tb failed");
            $finish;
         end
      end
   end

   // Number driver
   always @(negedge clock) begin
      if (reset) begin
         req_offering = 1'b0;
         req_if.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            req_gap = draw_gap();
            req_offering = 1'b0;
         end
         if (!req_offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_numbers.size() > 0) begin
               req_if.number <= pending_numbers.pop_front();
               req_offering = 1'b1;
            end
         end
         req_if.valid <= req_offering;
      end
   end

   // Write receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_hold_token != rsp_hold_seen) begin
            rsp_hold_seen = rsp_hold_token;
            rsp_hold_left = LONG_HOLD;
         end
         if (rsp_fire) rsp_wait = draw_gap();
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic queue_number(input logic [NUMBER_W-1:0] number);
      pending_numbers.push_back(number);
      numbers_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (numbers_taken != numbers_queued || digit_writes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mostly numbers of a random decimal length, some zeros and full-width values.
   function automatic logic [NUMBER_W-1:0] random_number();
      int unsigned pick;
      int unsigned len;
      int unsigned lo;
      int unsigned hi;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick < 3) return NUMBER_W'($urandom());
      len = $urandom_range(1, 9);
      lo = 1;
      for (int i = 1; i < len; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (len == 1) lo = 1;
      if (hi > (1 << NUMBER_W) - 1) hi = (1 << NUMBER_W) - 1;
      return NUMBER_W'($urandom_range(hi, lo));
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] nd_data;
      req_if.valid  = 1'b0;
      req_if.number = '0;
      rsp_if.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_index     = REG_NUM_DIGITS;
      csr_wdata     = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset settings: eight digits, no points
      queue_number(0);
      queue_number(1);
      queue_number(9);
      queue_number(10);
      queue_number(12345678);
      queue_number(99999999);
      queue_number(100000000);
      queue_number({NUMBER_W{1'b1}});
      wait_drained();

      // single digit, all points
      write_csr(REG_NUM_DIGITS, 8'h01);
      write_csr(REG_DP_MASK, 8'hFF);
      queue_number(0);
      queue_number(7);
      queue_number(10);
      queue_number(99999999);
      queue_number(5);
      queue_number({NUMBER_W{1'b1}});
      wait_drained();

      // zero digit count, upper data bits set
      write_csr(REG_NUM_DIGITS, 8'hF0);
      write_csr(REG_DP_MASK, 8'h55);
      queue_number(0);
      queue_number(3);
      queue_number(42);
      queue_number(1);
      wait_drained();

      // digit count above the maximum, writes to unmapped indexes
      write_csr(REG_NUM_DIGITS, 8'h0F);
      write_csr(REG_DP_MASK, 8'hAA);
      write_csr(REG_UNMAPPED_LO, CSR_DATA_W'($urandom()));
      write_csr(REG_UNMAPPED_HI, CSR_DATA_W'($urandom()));
      queue_number(0);
      queue_number(10000000);
      queue_number(90000009);
      queue_number(99999999);
      queue_number(100000000);
      queue_number(87654321);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         nd_data = CSR_DATA_W'($urandom());
         if (p == 0) nd_data[NUM_DIGITS_W-1:0] = 4'd8;
         else if (p == 1) nd_data[NUM_DIGITS_W-1:0] = 4'd1;
         else if ($urandom_range(0, 3) != 0)
            nd_data[NUM_DIGITS_W-1:0] = NUM_DIGITS_W'($urandom_range(1, MAX_DIGITS));
         write_csr(REG_NUM_DIGITS, nd_data);
         if (p == 2) write_csr(REG_DP_MASK, 8'hFF);
         else if (p == 3) write_csr(REG_DP_MASK, 8'h00);
         else write_csr(REG_DP_MASK, CSR_DATA_W'($urandom()));
         no_idle = (p == 4);
         if (p == 5) rsp_hold_token++;
         for (int i = 0; i < PHASE_ITEMS; i++) queue_number(random_number());
         wait_drained();
         no_idle = 1'b0;
      end

      if (digit_writes_due.size() != 0)
         report_error($sformatf("%0d writes never arrived", digit_writes_due.size()));
      if (err_count == 0) begin
         $display("int_to_digit_register_writes_unit_tb passed");
      end else begin
         $display("int_to_digit_register_writes_unit_tb failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/itdrw_pkg.sv
design/itdrw_channels.sv
design/itdrw_ctrl.sv
design/itdrw_datapath.sv
design/int_to_digit_register_writes_unit.sv
dv/int_to_digit_register_writes_unit_tb.sv
